FILE: hw/rtl/source_token_scanner_unit_macros.svh
// Assertion macros for the source token scanner.
// Used by the front-end, queue and top-level files.
`ifndef SOURCE_TOKEN_SCANNER_UNIT_MACROS_SVH
`define SOURCE_TOKEN_SCANNER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define STS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define STS_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define STS_ASSERT(label, clk, rst_n, prop)
`define STS_ASSERT_RST(label, clk, prop)
`endif
`endif

FILE: hw/rtl/sts_pkg.sv
// Package for the source token scanner: token types, result bundle, byte classes.
// No dependencies.
package sts_pkg;
    localparam int LINE_BITS_DEF = 24;
    localparam int MAX_RES = 6;

    localparam logic [3:0] TT_EOF = 4'd0;
    localparam logic [3:0] TT_ERR = 4'd1;
    localparam logic [3:0] TT_DEC = 4'd2;
    localparam logic [3:0] TT_HEX = 4'd3;
    localparam logic [3:0] TT_OCT = 4'd4;
    localparam logic [3:0] TT_BIN = 4'd5;
    localparam logic [3:0] TT_STR = 4'd6;
    localparam logic [3:0] TT_ID = 4'd7;
    localparam logic [3:0] TT_ARROW = 4'd8;
    localparam logic [3:0] TT_EQUAL = 4'd9;
    localparam logic [3:0] TT_PUNCT = 4'd10;

    // One result event without the line number.
    typedef struct packed {
        logic       what;
        logic [7:0] value;
        logic [3:0] ttype;
    } t_ev;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_idstart(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "+" ||
               c == "-" || c == "*" || c == "/" || c == "%" || c == "_" || c == "#";
    endfunction

    function automatic logic is_cont(input logic [7:0] c);
        return c == "?" || c == "!" || c == ">" || is_idstart(c) || is_digit(c);
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return c == "(" || c == ")" || c == "{" || c == "}" || c == "[" ||
               c == "]" || c == "<" || c == ">" || c == ":" || c == "." ||
               c == "," || c == "|" || c == 8'h5c || c == 8'h27;
    endfunction
endpackage

FILE: hw/rtl/sts_front.sv
// Front end of the source token scanner: scanning state machine that turns
// one byte into up to five events combinationally. Depends on sts_pkg.
`include "source_token_scanner_unit_macros.svh"
module sts_front #(
    parameter int LINE_BITS = sts_pkg::LINE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [7:0]              i_ch,
    input  logic                    i_eoi,
    input  logic                    i_space,
    output logic                    o_ready,
    output logic                    o_push,
    output logic [2:0]              o_cnt,
    output sts_pkg::t_ev [5:0]      o_evs,
    output logic [LINE_BITS-1:0]    o_line
);
    import sts_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_COMMENT, S_STRING, S_IDENT, S_IDDASH, S_MINUS, S_EQ, S_ZERO,
        S_DEC, S_DECDOT, S_FRAC, S_HEX, S_OCT, S_BIN
    } t_mode;

    t_mode                 r_mode, n_mode;
    logic [LINE_BITS-1:0]  r_line, n_line;
    logic [LINE_BITS-1:0]  ev_line;
    logic [7:0]            r_held, n_held;
    logic                  r_esc, n_esc;
    logic                  r_bad, n_bad;
    t_ev [5:0]             evs;
    logic [2:0]            cnt;
    logic                  fire;

    assign o_ready = i_space;
    assign fire    = i_valid && i_space;

    // Events carry the count before this byte; only a newline inside a string
    // counts before its own literal. A newline rescanned from idle comes after
    // the events that end the previous token.
    always_comb begin
        logic [7:0] c;
        logic [7:0] h;
        logic       again;
        t_mode      m;
        c = i_ch;
        h = r_held;
        n_mode = r_mode;
        n_line = r_line;
        ev_line = r_line;
        n_held = r_held;
        n_esc  = r_esc;
        n_bad  = r_bad;
        evs    = '0;
        cnt    = '0;
        m      = r_mode;
        again  = 1'b0;
        if (i_eoi) begin
            case (r_mode)
                S_STRING: begin
                    evs[0] = '{1'b1, 8'd0, TT_ERR}; cnt = 3'd1;
                end
                S_IDENT: begin
                    evs[0] = '{1'b1, 8'd0, TT_ID}; cnt = 3'd1;
                end
                S_IDDASH, S_MINUS: begin
                    evs[0] = '{1'b0, h, TT_EOF}; evs[1] = '{1'b1, 8'd0, TT_ID};
                    cnt = 3'd2;
                end
                S_EQ: begin
                    evs[0] = '{1'b0, h, TT_EOF}; evs[1] = '{1'b1, h, TT_PUNCT};
                    cnt = 3'd2;
                end
                S_ZERO: begin
                    evs[0] = '{1'b0, h, TT_EOF}; evs[1] = '{1'b1, 8'd0, TT_DEC};
                    cnt = 3'd2;
                end
                S_DEC, S_FRAC: begin
                    evs[0] = '{1'b1, 8'd0, TT_DEC}; cnt = 3'd1;
                end
                S_DECDOT: begin
                    evs[0] = '{1'b1, 8'd0, TT_DEC}; evs[1] = '{1'b0, h, TT_EOF};
                    evs[2] = '{1'b1, h, TT_PUNCT}; cnt = 3'd3;
                end
                S_HEX: begin
                    evs[0] = '{1'b1, 8'd0, TT_HEX}; cnt = 3'd1;
                end
                S_OCT: begin
                    evs[0] = '{1'b1, 8'd0, TT_OCT}; cnt = 3'd1;
                end
                S_BIN: begin
                    evs[0] = '{1'b1, 8'd0, TT_BIN}; cnt = 3'd1;
                end
                default: ;
            endcase
            evs[cnt] = '{1'b1, 8'd0, TT_EOF};
            cnt = cnt + 3'd1;
            n_mode = S_IDLE;
            n_line = LINE_BITS'(1);
            n_held = '0;
            n_esc  = 1'b0;
            n_bad  = 1'b0;
        end else begin
            // First pass: modes that consume or hand back the byte.
            case (m)
                S_COMMENT: begin
                    if (c == 8'h0a) begin
                        if (~&r_line) n_line = r_line + 1'b1;
                        n_mode = S_IDLE;
                    end
                end
                S_STRING: begin
                    if (c == 8'h22) begin
                        evs[0] = '{1'b1, 8'd0, (r_bad || r_esc) ? TT_ERR : TT_STR};
                        cnt = 3'd1; n_esc = 1'b0; n_bad = 1'b0; n_mode = S_IDLE;
                    end else begin
                        if (c == 8'h0a && ~&r_line) n_line = r_line + 1'b1;
                        ev_line = n_line;
                        if (r_esc) begin
                            n_esc = 1'b0;
                            cnt = 3'd1;
                            case (c)
                                "n":   evs[0] = '{1'b0, 8'h0a, TT_EOF};
                                "t":   evs[0] = '{1'b0, 8'h09, TT_EOF};
                                "f":   evs[0] = '{1'b0, 8'h0c, TT_EOF};
                                8'h5c: evs[0] = '{1'b0, 8'h5c, TT_EOF};
                                default: begin
                                    cnt = 3'd0; n_bad = 1'b1;
                                end
                            endcase
                        end else if (c == 8'h5c) begin
                            n_esc = 1'b1;
                        end else begin
                            evs[0] = '{1'b0, c, TT_EOF}; cnt = 3'd1;
                        end
                    end
                end
                S_IDENT: begin
                    if (c == "-") begin
                        n_held = c; n_mode = S_IDDASH;
                    end else if (is_cont(c)) begin
                        evs[0] = '{1'b0, c, TT_EOF}; cnt = 3'd1;
                    end else begin
                        evs[0] = '{1'b1, 8'd0, TT_ID}; cnt = 3'd1; again = 1'b1;
                    end
                end
                S_IDDASH: begin
                    // Dash plus '>' ends the identifier and rescans the dash.
                    if (c == ">") begin
                        evs[0] = '{1'b1, 8'd0, TT_ID}; cnt = 3'd1;
                        n_held = h; n_mode = S_MINUS;
                        // held dash starts a minus form; now scan c in it
                        evs[1] = '{1'b0, h, TT_EOF}; evs[2] = '{1'b0, c, TT_EOF};
                        evs[3] = '{1'b1, 8'd0, TT_ARROW}; cnt = 3'd4;
                        n_mode = S_IDLE;
                    end else begin
                        evs[0] = '{1'b0, h, TT_EOF}; cnt = 3'd1;
                        if (c == "-") begin
                            n_held = c; n_mode = S_IDDASH;
                        end else if (is_cont(c)) begin
                            evs[1] = '{1'b0, c, TT_EOF}; cnt = 3'd2; n_mode = S_IDENT;
                        end else begin
                            evs[1] = '{1'b1, 8'd0, TT_ID}; cnt = 3'd2; again = 1'b1;
                        end
                    end
                end
                S_MINUS: begin
                    if (c == ">") begin
                        evs[0] = '{1'b0, h, TT_EOF}; evs[1] = '{1'b0, c, TT_EOF};
                        evs[2] = '{1'b1, 8'd0, TT_ARROW}; cnt = 3'd3; n_mode = S_IDLE;
                    end else if (is_idstart(c) || is_digit(c)) begin
                        evs[0] = '{1'b0, h, TT_EOF}; evs[1] = '{1'b0, c, TT_EOF};
                        cnt = 3'd2; n_mode = S_IDENT;
                    end else begin
                        evs[0] = '{1'b0, h, TT_EOF}; evs[1] = '{1'b1, 8'd0, TT_ID};
                        cnt = 3'd2; again = 1'b1;
                    end
                end
                S_EQ: begin
                    if (c == "=" || c == ">") begin
                        evs[0] = '{1'b0, h, TT_EOF}; evs[1] = '{1'b0, c, TT_EOF};
                        evs[2] = '{1'b1, 8'd0, (c == "=") ? TT_EQUAL : TT_ID};
                        cnt = 3'd3; n_mode = S_IDLE;
                    end else begin
                        evs[0] = '{1'b0, h, TT_EOF}; evs[1] = '{1'b1, h, TT_PUNCT};
                        cnt = 3'd2; again = 1'b1;
                    end
                end
                S_ZERO: begin
                    if (c == "x") n_mode = S_HEX;
                    else if (c == "o") n_mode = S_OCT;
                    else if (c == "b") n_mode = S_BIN;
                    else if (is_digit(c)) begin
                        evs[0] = '{1'b0, h, TT_EOF}; evs[1] = '{1'b0, c, TT_EOF};
                        cnt = 3'd2; n_mode = S_DEC;
                    end else begin
                        evs[0] = '{1'b0, h, TT_EOF}; evs[1] = '{1'b1, 8'd0, TT_DEC};
                        cnt = 3'd2; again = 1'b1;
                    end
                end
                S_DEC: begin
                    if (is_digit(c)) begin
                        evs[0] = '{1'b0, c, TT_EOF}; cnt = 3'd1;
                    end else if (c == ".") begin
                        n_held = c; n_mode = S_DECDOT;
                    end else begin
                        evs[0] = '{1'b1, 8'd0, TT_DEC}; cnt = 3'd1; again = 1'b1;
                    end
                end
                S_DECDOT: begin
                    if (is_digit(c)) begin
                        evs[0] = '{1'b0, h, TT_EOF}; evs[1] = '{1'b0, c, TT_EOF};
                        cnt = 3'd2; n_mode = S_FRAC;
                    end else begin
                        evs[0] = '{1'b1, 8'd0, TT_DEC}; evs[1] = '{1'b0, h, TT_EOF};
                        evs[2] = '{1'b1, h, TT_PUNCT}; cnt = 3'd3; again = 1'b1;
                    end
                end
                S_FRAC: begin
                    if (is_digit(c)) begin
                        evs[0] = '{1'b0, c, TT_EOF}; cnt = 3'd1;
                    end else begin
                        evs[0] = '{1'b1, 8'd0, TT_DEC}; cnt = 3'd1; again = 1'b1;
                    end
                end
                S_HEX, S_OCT, S_BIN: begin
                    if ((m == S_HEX && (is_digit(c) || (c >= "a" && c <= "f"))) ||
                        (m == S_OCT && c >= "0" && c <= "7") ||
                        (m == S_BIN && (c == "0" || c == "1"))) begin
                        evs[0] = '{1'b0, c, TT_EOF}; cnt = 3'd1;
                    end else begin
                        evs[0] = '{1'b1, 8'd0,
                                   (m == S_HEX) ? TT_HEX : (m == S_OCT) ? TT_OCT : TT_BIN};
                        cnt = 3'd1; again = 1'b1;
                    end
                end
                default: again = 1'b1;
            endcase
            // Second pass: scan the byte afresh from idle.
            if (again) begin
                n_mode = S_IDLE;
                if (c == " " || c == 8'h0d || c == 8'h09) begin
                end else if (c == 8'h0a) begin
                    if (~&r_line) n_line = r_line + 1'b1;
                end else if (c == ";") begin
                    n_mode = S_COMMENT;
                end else if (is_punct(c)) begin
                    evs[cnt] = '{1'b0, c, TT_EOF};
                    evs[cnt + 3'd1] = '{1'b1, c, TT_PUNCT};
                    cnt = cnt + 3'd2;
                end else if (c == "0") begin
                    n_held = c; n_mode = S_ZERO;
                end else if (is_digit(c)) begin
                    evs[cnt] = '{1'b0, c, TT_EOF}; cnt = cnt + 3'd1; n_mode = S_DEC;
                end else if (c == 8'h22) begin
                    n_esc = 1'b0; n_bad = 1'b0; n_mode = S_STRING;
                end else if (c == "-") begin
                    n_held = c; n_mode = S_MINUS;
                end else if (c == "=") begin
                    n_held = c; n_mode = S_EQ;
                end else if (is_idstart(c)) begin
                    evs[cnt] = '{1'b0, c, TT_EOF}; cnt = cnt + 3'd1; n_mode = S_IDENT;
                end else begin
                    evs[cnt] = '{1'b0, c, TT_EOF};
                    evs[cnt + 3'd1] = '{1'b1, 8'd0, TT_ERR};
                    cnt = cnt + 3'd2;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= S_IDLE;
            r_line <= LINE_BITS'(1);
            r_esc  <= 1'b0;
            r_bad  <= 1'b0;
        end else if (fire) begin
            r_mode <= n_mode;
            r_line <= n_line;
            r_esc  <= n_esc;
            r_bad  <= n_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) r_held <= n_held;
    end

    assign o_push = fire && (cnt != 3'd0);
    assign o_cnt  = cnt;
    assign o_evs  = evs;
    assign o_line = ev_line;

    `STS_ASSERT(a_cnt_max, i_clk, i_rst_n, o_push |-> (o_cnt <= 3'd6))
    `STS_ASSERT(a_eoi_line, i_clk, i_rst_n, (fire && i_eoi) |=> (r_line == LINE_BITS'(1)))
    `STS_ASSERT(a_line_nonzero, i_clk, i_rst_n, r_line != '0)
endmodule

FILE: hw/rtl/sts_queue.sv
// Event bundle queue between front end and output stage of the token scanner.
// Holds whole input results; depends on sts_pkg.
`include "source_token_scanner_unit_macros.svh"
module sts_queue #(
    parameter int LINE_BITS = sts_pkg::LINE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic [2:0]              i_cnt,
    input  sts_pkg::t_ev [5:0]      i_evs,
    input  logic [LINE_BITS-1:0]    i_line,
    output logic                    o_space,
    output logic                    o_valid,
    output logic                    o_what,
    output logic [7:0]              o_value,
    output logic [3:0]              o_ttype,
    output logic [LINE_BITS-1:0]    o_line,
    output logic                    o_last,
    input  logic                    i_ready
);
    import sts_pkg::*;

    localparam int DEPTH = 2;

    t_ev [5:0]            r_evs [DEPTH];
    logic [2:0]           r_cnt [DEPTH];
    logic [LINE_BITS-1:0] r_lines [DEPTH];
    logic                 r_wp, r_rp;
    logic [1:0]           r_fill;
    logic [2:0]           r_idx;
    logic                 pop_ev, pop_bundle;

    assign o_space   = (r_fill != 2'd2);
    assign o_valid   = (r_fill != 2'd0);
    assign o_what    = r_evs[r_rp][r_idx].what;
    assign o_value   = r_evs[r_rp][r_idx].value;
    assign o_ttype   = r_evs[r_rp][r_idx].ttype;
    assign o_line    = r_lines[r_rp];
    assign o_last    = (r_idx + 3'd1 == r_cnt[r_rp]);
    assign pop_ev    = o_valid && i_ready;
    assign pop_bundle = pop_ev && o_last;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_evs[r_wp]   <= i_evs;
            r_cnt[r_wp]   <= i_cnt;
            r_lines[r_wp] <= i_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
            r_idx  <= 3'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (pop_bundle) r_rp <= ~r_rp;
            r_fill <= r_fill + {1'b0, i_push} - {1'b0, pop_bundle};
            if (pop_bundle) r_idx <= 3'd0;
            else if (pop_ev) r_idx <= r_idx + 3'd1;
        end
    end

    `STS_ASSERT(a_no_overflow, i_clk, i_rst_n, i_push |-> (o_space || pop_bundle))
    `STS_ASSERT(a_idx_range, i_clk, i_rst_n, o_valid |-> (r_idx < r_cnt[r_rp]))
    `STS_ASSERT(a_idle_idx, i_clk, i_rst_n, !o_valid |-> (r_idx == 3'd0))
endmodule

FILE: hw/rtl/source_token_scanner_unit.sv
// Top level of the source token scanner: front-end scanner and event queue.
// Depends on sts_pkg, sts_front and sts_queue.
//
//  channel | dir | tdata                         | tuser
//  s_axis  | in  | ch[7:0]                       | end_of_input
//  m_axis  | out | value[7:0] type[11:8] line.. | what
//
// One byte is taken each cycle while the queue holds a free bundle slot; the
// front scanner resolves a byte with all its lookahead in that cycle.
// Results leave one per cycle while m_axis_tready is high, so the event count
// per byte sets the throughput.
// Reset is synchronous and returns the scanner to line one with queue empty.
// An output stall holds the front only once both queue slots are full.
`include "source_token_scanner_unit_macros.svh"
module source_token_scanner_unit #(
    parameter int LINE_BITS = sts_pkg::LINE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // ch[7:0]
    input  logic       s_axis_tuser,   // end_of_input
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    // value[7:0], token_type[11:8], line[LINE_BITS+11:12], zero fill
    output logic [((LINE_BITS+12+7)/8)*8-1:0] m_axis_tdata,
    output logic       m_axis_tuser,   // what
    output logic       m_axis_tlast    // last
);
    import sts_pkg::*;

    localparam int DW = ((LINE_BITS + 12 + 7) / 8) * 8;

    logic                 space, push;
    logic [2:0]           cnt;
    t_ev [5:0]            evs;
    logic [LINE_BITS-1:0] fline, qline;
    logic [7:0]           qvalue;
    logic [3:0]           qtype;

    // Scan one byte into a bundle of events.
    sts_front #(.LINE_BITS(LINE_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .i_ch(s_axis_tdata), .i_eoi(s_axis_tuser),
        .i_space(space), .o_ready(s_axis_tready),
        .o_push(push), .o_cnt(cnt), .o_evs(evs), .o_line(fline)
    );

    // Hold bundles and replay their events one per transaction.
    sts_queue #(.LINE_BITS(LINE_BITS)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_cnt(cnt), .i_evs(evs), .i_line(fline),
        .o_space(space), .o_valid(m_axis_tvalid), .o_what(m_axis_tuser),
        .o_value(qvalue), .o_ttype(qtype), .o_line(qline), .o_last(m_axis_tlast),
        .i_ready(m_axis_tready)
    );

    assign m_axis_tdata = DW'({qline, qtype, qvalue});

    `STS_ASSERT(a_eoi_emits, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready && s_axis_tuser) |-> push)
    `STS_ASSERT(a_last_end, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tlast && !m_axis_tuser) |-> (qtype == TT_EOF))
    `STS_ASSERT(a_lit_type, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tuser) |-> (qtype == TT_EOF))
endmodule
